### rtl/core/deuc_pkg.sv
`default_nettype none

package deuc_pkg;

  // Default sizes of the counter bank
  localparam int unsigned MaxNodesDef   = 16;
  localparam int unsigned MaxExpertsDef = 64;

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned EidW    = 6;
  localparam int unsigned MaskW   = 64;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned ProdW   = AlphaW + CountW;

  // Stream word widths, padded to whole bytes
  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgDecay = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIncr  = 2'd1;

  // Q1.16 unity and beta reset value, both 1.0 at 16 fractional bits
  localparam logic [AlphaW-1:0] AlphaOne  = 17'd65536;
  localparam logic [CountW-1:0] BetaReset = 32'd65536;

  typedef enum logic [CmdW-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_USAGE    = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 3'd0,
    STATUS_UNKNOWN = 3'd1,
    STATUS_RANGE   = 3'd2,
    STATUS_DUP     = 3'd3,
    STATUS_SAT     = 3'd4,
    STATUS_ZERO    = 3'd5
  } status_e;

  // Control that travels with a counter into the decay unit
  typedef struct packed {
    logic valid;
    logic used;
  } dcy_ctl_t;

  // Updated counter leaving the decay unit
  typedef struct packed {
    logic              valid;
    logic              sat;
    logic [CountW-1:0] value;
  } dcy_res_t;

endpackage

`default_nettype wire

### rtl/core/deuc_ram.sv
`default_nettype none

module deuc_ram #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/deuc_decay.sv
`default_nettype none

module deuc_decay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  deuc_pkg::dcy_ctl_t                  ctl_i,
  input  logic [deuc_pkg::CountW-1:0]         count_i,
  input  logic [deuc_pkg::AlphaW-1:0]         alpha_i,
  input  logic [deuc_pkg::CountW-1:0]         beta_i,
  output deuc_pkg::dcy_res_t                  res_o
);

  import deuc_pkg::*;

  logic [ProdW-1:0]  prod_q;
  logic              used_q;
  logic              valid_q;
  logic [ProdW-1:0]  rounded_full;
  logic [CountW:0]   rounded;
  logic [CountW+1:0] sum;
  logic              sat;

  // Register the product of alpha and the counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      used_q  <= 1'b0;
      prod_q  <= '0;
    end else begin
      valid_q <= ctl_i.valid;
      used_q  <= ctl_i.used;
      prod_q  <= ProdW'(alpha_i) * ProdW'(count_i);
    end
  end

  // Round to nearest, add beta for a used expert, saturate
  assign rounded_full = (prod_q + ProdW'(32768)) >> 16;
  assign rounded      = rounded_full[CountW:0];
  assign sum          = {1'b0, rounded} + {2'b00, (used_q ? beta_i : '0)};
  assign sat          = |sum[CountW+1:CountW];

  assign res_o.valid = valid_q;
  assign res_o.sat   = sat;
  assign res_o.value = sat ? '1 : sum[CountW-1:0];

endmodule

`default_nettype wire

### rtl/core/decayed_expert_usage_counters_core.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  command, slot, count, id, mask, value
// m_axis    out        m_axis_tvalid/m_axis_tready  status, read_value
// cfg       in         cfg_we_i (no wait)           decay_factor, usage_increment
//
// One request at a time. A write or a rejected request goes to the done state, a read
// passes the read state, a registration zeroes its counters and a usage record
// sweeps the node: the memory has one read and one write port and the decay pipeline
// moves one counter per cycle. No clearing pass after reset: a node's counters are
// zeroed when it registers. A new request is taken while a result waits.

module decayed_expert_usage_counters_core #(
  parameter int unsigned MAX_NODES   = deuc_pkg::MaxNodesDef,
  parameter int unsigned MAX_EXPERTS = deuc_pkg::MaxExpertsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command [1:0], node_slot [5:2], num_experts [12:6], counter_idx [18:13],
  // used_mask [82:19], write_value [114:83], zero [119:115]
  input  logic [deuc_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // status [2:0], read_value [34:3], zero [39:35]
  output logic [deuc_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [deuc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [deuc_pkg::CfgDataW-1:0]   cfg_data_i
);

  import deuc_pkg::*;

  localparam int unsigned NodeW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned ExpW   = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
  localparam int unsigned SlotXW = (NodeW > SlotW) ? NodeW : SlotW;
  localparam int unsigned AddrW  = NodeW + ExpW;
  localparam logic [8:0]       NodesLim = 9'(MAX_NODES);
  localparam logic [SizeW-1:0] ExpLim   = SizeW'(MAX_EXPERTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DECAY,
    ST_READ,
    ST_DONE
  } state_e;

  // Request fields
  cmd_e              in_cmd;
  logic [SlotW-1:0]  in_slot;
  logic [SizeW-1:0]  in_count;
  logic [EidW-1:0]   in_eid;
  logic [MaskW-1:0]  in_mask;
  logic [CountW-1:0] in_wval;
  logic [SlotXW-1:0] in_slot_x;
  logic [NodeW-1:0]  in_slot_idx;
  logic [ExpW-1:0]   in_eid_idx;
  logic              slot_ok;
  logic [SizeW-1:0]  cur_size;
  logic              mask_bad;
  logic              s_acc;

  // State
  state_e            state_q, state_d;
  logic [SizeW-1:0]  size_q [MAX_NODES];
  logic [SizeW-1:0]  size_d [MAX_NODES];
  logic              any_reg_q, any_reg_d;
  logic [AlphaW-1:0] alpha_q, alpha_d;
  logic [CountW-1:0] beta_q, beta_d;
  logic [NodeW-1:0]  slot_q, slot_d;
  logic [SizeW-1:0]  limit_q, limit_d;
  logic [SizeW-1:0]  rd_cnt_q, rd_cnt_d;
  logic [SizeW-1:0]  wr_cnt_q, wr_cnt_d;
  logic [MaskW-1:0]  mask_q, mask_d;
  logic              s1_v_q, s1_v_d;
  logic              s1_used_q, s1_used_d;
  logic              sat_q, sat_d;
  status_e           res_status_q, res_status_d;
  logic [CountW-1:0] res_value_q, res_value_d;
  logic              m_valid_q, m_valid_d;
  status_e           m_status_q, m_status_d;
  logic [CountW-1:0] m_value_q, m_value_d;

  // Memory port and decay unit
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [CountW-1:0] ram_rdata;
  dcy_ctl_t          dcy_ctl;
  dcy_res_t          dcy_res;

  // Unpack the request
  assign in_cmd      = cmd_e'(s_axis_tdata[1:0]);
  assign in_slot     = s_axis_tdata[5:2];
  assign in_count    = s_axis_tdata[12:6];
  assign in_eid      = s_axis_tdata[18:13];
  assign in_mask     = s_axis_tdata[82:19];
  assign in_wval     = s_axis_tdata[114:83];
  assign in_slot_x   = SlotXW'(in_slot);
  assign in_slot_idx = in_slot_x[NodeW-1:0];
  assign in_eid_idx  = in_eid[ExpW-1:0];
  assign slot_ok     = {5'b00000, in_slot} < NodesLim;
  assign cur_size    = slot_ok ? size_q[in_slot_idx] : '0;
  assign mask_bad    = |(in_mask & ({MaskW{1'b1}} << cur_size));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Next state, memory port and result
  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    any_reg_d    = any_reg_q;
    alpha_d      = alpha_q;
    beta_d       = beta_q;
    slot_d       = slot_q;
    limit_d      = limit_q;
    rd_cnt_d     = rd_cnt_q;
    wr_cnt_d     = wr_cnt_q;
    mask_d       = mask_q;
    s1_v_d       = 1'b0;
    s1_used_d    = s1_used_q;
    sat_d        = sat_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_value_d    = m_value_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    // Settings change only while no node is registered
    if (cfg_we_i && !any_reg_q) begin
      case (cfg_idx_i)
        CfgDecay: begin
          if (cfg_data_i[AlphaW-1:0] <= AlphaOne) begin
            alpha_d = cfg_data_i[AlphaW-1:0];
          end
        end
        CfgIncr: beta_d = cfg_data_i;
        default: ;
      endcase
    end

    // Drop a delivered result
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d     = ST_DONE;
          slot_d      = in_slot_idx;
          res_value_d = '0;
          if (!slot_ok) begin
            res_status_d = STATUS_UNKNOWN;
          end else if (in_cmd == CMD_REGISTER) begin
            if (in_count == '0) begin
              res_status_d = STATUS_ZERO;
            end else if (cur_size != '0) begin
              res_status_d = STATUS_DUP;
            end else if (in_count > ExpLim) begin
              res_status_d = STATUS_RANGE;
            end else begin
              res_status_d        = STATUS_OK;
              size_d[in_slot_idx] = in_count;
              any_reg_d           = 1'b1;
              limit_d             = in_count;
              wr_cnt_d            = '0;
              state_d             = ST_CLEAR;
            end
          end else if (cur_size == '0) begin
            res_status_d = STATUS_UNKNOWN;
          end else if (in_cmd == CMD_USAGE) begin
            if (mask_bad) begin
              res_status_d = STATUS_RANGE;
            end else begin
              res_status_d = STATUS_OK;
              limit_d      = cur_size;
              mask_d       = in_mask;
              rd_cnt_d     = '0;
              wr_cnt_d     = '0;
              sat_d        = 1'b0;
              state_d      = ST_DECAY;
            end
          end else if ({1'b0, in_eid} >= cur_size) begin
            res_status_d = STATUS_RANGE;
          end else if (in_cmd == CMD_WRITE) begin
            res_status_d = STATUS_OK;
            ram_we       = 1'b1;
            ram_waddr    = {in_slot_idx, in_eid_idx};
            ram_wdata    = in_wval;
          end else begin
            res_status_d = STATUS_OK;
            ram_re       = 1'b1;
            ram_raddr    = {in_slot_idx, in_eid_idx};
            state_d      = ST_READ;
          end
        end
      end

      // Zero the node's counters, one a cycle
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {slot_q, wr_cnt_q[ExpW-1:0]};
        ram_wdata = '0;
        wr_cnt_d  = wr_cnt_q + 1'b1;
        if (wr_cnt_q == limit_q - 1'b1) begin
          state_d = ST_DONE;
        end
      end

      // Stream the node's counters through the decay unit and write them back
      ST_DECAY: begin
        if (rd_cnt_q < limit_q) begin
          ram_re    = 1'b1;
          ram_raddr = {slot_q, rd_cnt_q[ExpW-1:0]};
          rd_cnt_d  = rd_cnt_q + 1'b1;
          mask_d    = mask_q >> 1;
          s1_v_d    = 1'b1;
          s1_used_d = mask_q[0];
        end
        if (dcy_res.valid) begin
          ram_we    = 1'b1;
          ram_waddr = {slot_q, wr_cnt_q[ExpW-1:0]};
          ram_wdata = dcy_res.value;
          wr_cnt_d  = wr_cnt_q + 1'b1;
          if (dcy_res.sat) begin
            sat_d = 1'b1;
          end
          if (wr_cnt_q == limit_q - 1'b1) begin
            res_status_d = (sat_q || dcy_res.sat) ? STATUS_SAT : STATUS_OK;
            state_d      = ST_DONE;
          end
        end
      end

      ST_READ: begin
        res_value_d = ram_rdata;
        state_d     = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_value_d  = res_value_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int i = 0; i < MAX_NODES; i++) begin
        size_q[i] <= '0;
      end
      any_reg_q    <= 1'b0;
      alpha_q      <= AlphaOne;
      beta_q       <= BetaReset;
      slot_q       <= '0;
      limit_q      <= '0;
      rd_cnt_q     <= '0;
      wr_cnt_q     <= '0;
      mask_q       <= '0;
      s1_v_q       <= 1'b0;
      s1_used_q    <= 1'b0;
      sat_q        <= 1'b0;
      res_status_q <= STATUS_OK;
      res_value_q  <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= STATUS_OK;
      m_value_q    <= '0;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      any_reg_q    <= any_reg_d;
      alpha_q      <= alpha_d;
      beta_q       <= beta_d;
      slot_q       <= slot_d;
      limit_q      <= limit_d;
      rd_cnt_q     <= rd_cnt_d;
      wr_cnt_q     <= wr_cnt_d;
      mask_q       <= mask_d;
      s1_v_q       <= s1_v_d;
      s1_used_q    <= s1_used_d;
      sat_q        <= sat_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      m_valid_q    <= m_valid_d;
      m_status_q   <= m_status_d;
      m_value_q    <= m_value_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, m_value_q, m_status_q};

  // Counter memory
  deuc_ram #(
    .AddrW(AddrW),
    .DataW(CountW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decay and increment datapath
  assign dcy_ctl.valid = s1_v_q;
  assign dcy_ctl.used  = s1_used_q;

  deuc_decay u_decay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dcy_ctl),
    .count_i (ram_rdata),
    .alpha_i (alpha_q),
    .beta_i  (beta_q),
    .res_o   (dcy_res)
  );

  // Read and write never meet on one counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("counter read and write collide");

  // Writes never overtake reads during a decay sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECAY) |-> ((wr_cnt_q <= rd_cnt_q) && (rd_cnt_q <= limit_q)))
    else $error("decay sweep counters out of order");

  // One request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while busy");

  // A new result only comes from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done state");

  // Registration is permanent until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(any_reg_q))
    else $error("registered flag dropped");

endmodule

`default_nettype wire

### tb/sv/decayed_expert_usage_counters_core_tb.sv
`timescale 1ns / 1ps

module decayed_expert_usage_counters_core_tb;
  import deuc_pkg::*;

  localparam int unsigned Nodes       = MaxNodesDef;
  localparam int unsigned Experts     = MaxExpertsDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 730;
  localparam int unsigned TailCycles  = 80;
  localparam int unsigned MaxReports  = 150;
  localparam int unsigned IdlePct     = 31;

  // Register indexes past the end of the register list
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    cmd_e               cmd;
    logic [SlotW-1:0]   slot;
    logic [SizeW-1:0]   count;
    logic [EidW-1:0]    eid;
    logic [MaskW-1:0]   mask;
    logic [CountW-1:0]  wval;
  } request_t;

  typedef struct {
    status_e            status;
    logic [CountW-1:0]  value;
  } reply_t;

  // Mirror of the counter bank; predicts one reply per request and checks it
  class usage_bank_sb;
    logic [CountW-1:0] counters [Nodes][Experts];
    logic [SizeW-1:0]  node_size [Nodes];
    logic [AlphaW-1:0] alpha;
    logic [CountW-1:0] beta;
    reply_t            awaited_replies [$];
    int unsigned       n_requests;
    int unsigned       n_replies;
    int unsigned       n_errors;
    int unsigned       status_seen [8];

    function new();
      alpha = AlphaOne;
      beta = BetaReset;
      foreach (counters[s, e]) counters[s][e] = '0;
      foreach (node_size[s]) node_size[s] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      n_requests = 0;
      n_replies = 0;
      n_errors = 0;
    endfunction

    function bit any_registered();
      foreach (node_size[s]) if (node_size[s] != 0) return 1'b1;
      return 1'b0;
    endfunction

    // Registers freeze once any node is registered
    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (any_registered()) return;
      if (idx == CfgDecay) begin
        if (data[AlphaW-1:0] <= AlphaOne) alpha = data[AlphaW-1:0];
      end else if (idx == CfgIncr) begin
        beta = data;
      end
    endfunction

    function void take_request(request_t r);
      reply_t            rep;
      logic [SizeW-1:0]  size;
      logic [MaskW-1:0]  allowed;
      logic [63:0]       v;
      int                e;
      rep.status = STATUS_OK;
      rep.value = '0;
      size = node_size[r.slot];
      if (r.cmd == CMD_REGISTER) begin
        // zero count wins over duplicate, duplicate over oversize
        if (r.count == 0) rep.status = STATUS_ZERO;
        else if (size != 0) rep.status = STATUS_DUP;
        else if (r.count > Experts) rep.status = STATUS_RANGE;
        else begin
          node_size[r.slot] = r.count;
          for (e = 0; e < Experts; e++) counters[r.slot][e] = '0;
        end
      end else if (size == 0 || size > Experts) begin
        rep.status = STATUS_UNKNOWN;
      end else if (r.cmd == CMD_USAGE) begin
        allowed = (size >= MaskW) ? '1 : (64'd1 << size) - 64'd1;
        if ((r.mask & ~allowed) != 0) begin
          rep.status = STATUS_RANGE;
        end else begin
          // decay with round-half-up, add beta for used experts, saturate
          for (e = 0; e < size; e++) begin
            v = (64'(alpha) * 64'(counters[r.slot][e]) + 64'd32768) >> 16;
            if (r.mask[e]) v = v + 64'(beta);
            if (v > 64'hFFFF_FFFF) begin
              v = 64'hFFFF_FFFF;
              rep.status = STATUS_SAT;
            end
            counters[r.slot][e] = v[CountW-1:0];
          end
        end
      end else if (r.eid >= size) begin
        rep.status = STATUS_RANGE;
      end else if (r.cmd == CMD_WRITE) begin
        counters[r.slot][r.eid] = r.wval;
      end else begin
        rep.value = counters[r.slot][r.eid];
      end
      awaited_replies.insert(awaited_replies.size(), rep);
      status_seen[rep.status]++;
      n_requests++;
    endfunction

    function void check_reply(logic [OutDataW-1:0] word);
      reply_t             want;
      logic [StatusW-1:0] got_status;
      logic [CountW-1:0]  got_value;
      got_status = word[StatusW-1:0];
      got_value = word[StatusW +: CountW];
      n_replies++;
      if (awaited_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("%0t: reply with nothing pending: expected none, actual status %0d value %0h",
                   $time, got_status, got_value);
      end else begin
        want = awaited_replies.pop_front();
        if (got_status !== want.status) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got_status);
        end
        if (got_value !== want.value) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("%0t: read_value mismatch: expected %0h, actual %0h",
                     $time, want.value, got_value);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  usage_bank_sb sb = new();

  decayed_expert_usage_counters_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // No idling on either side inside this window of requests
  function automatic bit calm();
    return sb.n_requests >= 150 && sb.n_requests < 280;
  endfunction

  function automatic request_t make_req(cmd_e c, logic [SlotW-1:0] s, logic [SizeW-1:0] cnt,
                                        logic [EidW-1:0] id, logic [MaskW-1:0] m,
                                        logic [CountW-1:0] v);
    request_t r;
    r.cmd = c;
    r.slot = s;
    r.count = cnt;
    r.eid = id;
    r.mask = m;
    r.wval = v;
    return r;
  endfunction

  // Mostly well-formed traffic on registered nodes, some noise and broken requests
  function automatic request_t random_request();
    request_t          r;
    int unsigned       pick;
    logic [SizeW-1:0]  n;
    logic [MaskW-1:0]  allowed;
    r.cmd = cmd_e'(CmdW'($urandom_range(0, 3)));
    r.slot = SlotW'($urandom_range(0, Nodes - 1));
    r.count = SizeW'($urandom_range(0, 127));
    r.eid = EidW'($urandom_range(0, 63));
    r.mask = {$urandom, $urandom};
    r.wval = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) return r;
    if (pick < 14 || !sb.any_registered()) begin
      r.cmd = CMD_REGISTER;
      pick = $urandom_range(0, 9);
      r.count = (pick < 7) ? SizeW'($urandom_range(1, 8)) :
                (pick < 9) ? SizeW'($urandom_range(9, 63)) : 7'd64;
      return r;
    end
    while (sb.node_size[r.slot] == 0) r.slot = SlotW'($urandom_range(0, Nodes - 1));
    n = sb.node_size[r.slot];
    allowed = (n >= MaskW) ? '1 : (64'd1 << n) - 64'd1;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      r.cmd = CMD_USAGE;
      if ($urandom_range(0, 1) == 0) r.mask = r.mask & {$urandom, $urandom};
      r.mask = r.mask & allowed;
      // name an expert past the node's size now and then
      if ($urandom_range(0, 19) == 0 && n < MaskW) r.mask[$urandom_range(n, MaskW - 1)] = 1'b1;
    end else begin
      r.cmd = (pick < 68) ? CMD_WRITE : CMD_READ;
      r.eid = EidW'($urandom_range(0, n - 1));
      if ($urandom_range(0, 19) == 0 && n < Experts) r.eid = EidW'($urandom_range(n, Experts - 1));
      if ($urandom_range(0, 2) == 0) r.wval[CountW-1:16] = 16'hFFFF;
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then maybe drop valid for a gap
  task automatic send_request(request_t r);
    int unsigned gap;
    s_axis_tdata <= InDataW'({r.wval, r.mask, r.eid, r.count, r.slot, r.cmd});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_request(r);
    gap = 0;
    if (!calm()) while ($urandom_range(0, 99) < IdlePct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait for every pending reply
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  // Receiver: check replies, stall at random, one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
      if (!hold_done && sb.n_requests >= 450) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm() || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d replies pending",
             $time, cycles, sb.awaited_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned       pick;
    logic [AlphaW-1:0] alpha_pick;
    logic [CountW-1:0] beta_pick;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register extremes on an empty bank; upper bits of alpha are dropped
    cfg_write(CfgDecay, 32'd0);
    cfg_write(CfgDecay, 32'd65537);
    cfg_write(CfgIncr, 32'hFFFF_FFFF);
    cfg_write(CfgIncr, 32'd0);
    cfg_write(CfgSpareA, 32'hFFFF_FFFF);
    cfg_write(CfgSpareB, 32'h5555_AAAA);
    cfg_write(CfgDecay, 32'hFFFF_0000);
    cfg_we_i <= 1'b0;

    // Rejections while nothing is registered
    send_request(make_req(CMD_REGISTER, 4'd3, 7'd0, 6'd0, '0, '0));
    send_request(make_req(CMD_REGISTER, 4'd5, 7'd65, 6'd0, '0, '0));
    send_request(make_req(CMD_REGISTER, 4'd15, 7'd127, 6'd63, '1, '1));
    send_request(make_req(CMD_USAGE, 4'd0, 7'd0, 6'd0, '1, '0));
    send_request(make_req(CMD_WRITE, 4'd15, 7'd0, 6'd0, '0, 32'hFFFF_FFFF));
    send_request(make_req(CMD_READ, 4'd7, 7'd0, 6'd63, '0, '0));
    drain();

    // Setting in effect for the rest of the run
    pick = $urandom_range(0, 9);
    alpha_pick = (pick < 4) ? AlphaOne : (pick == 4) ? 17'd0 : 17'($urandom_range(32768, 65535));
    pick = $urandom_range(0, 9);
    beta_pick = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick < 6) ? 32'($urandom_range(1 << 10, 1 << 24)) : 32'($urandom);
    cfg_write(CfgDecay, 32'(alpha_pick));
    cfg_write(CfgIncr, beta_pick);
    cfg_we_i <= 1'b0;

    // Registration order checks, edges of ids and masks, saturation
    send_request(make_req(CMD_REGISTER, 4'd0, 7'd64, 6'd0, '0, '0));
    send_request(make_req(CMD_REGISTER, 4'd15, 7'd1, 6'd0, '0, '0));
    send_request(make_req(CMD_REGISTER, 4'd0, 7'd0, 6'd0, '0, '0));
    send_request(make_req(CMD_REGISTER, 4'd0, 7'd5, 6'd0, '0, '0));
    send_request(make_req(CMD_WRITE, 4'd0, 7'd0, 6'd63, '0, 32'hFFFF_FFFF));
    send_request(make_req(CMD_WRITE, 4'd0, 7'd0, 6'd0, '0, 32'hA5A5_5A5A));
    send_request(make_req(CMD_READ, 4'd0, 7'd0, 6'd63, '0, '0));
    send_request(make_req(CMD_USAGE, 4'd0, 7'd0, 6'd0, '1, '0));
    send_request(make_req(CMD_READ, 4'd0, 7'd0, 6'd63, '0, '0));
    send_request(make_req(CMD_USAGE, 4'd15, 7'd0, 6'd0, 64'h2, '0));
    send_request(make_req(CMD_USAGE, 4'd15, 7'd0, 6'd0, 64'h1, '0));
    send_request(make_req(CMD_USAGE, 4'd15, 7'd0, 6'd0, '0, '0));
    send_request(make_req(CMD_WRITE, 4'd15, 7'd0, 6'd1, '0, 32'h1234_5678));
    send_request(make_req(CMD_READ, 4'd15, 7'd0, 6'd63, '0, '0));
    send_request(make_req(CMD_READ, 4'd15, 7'd0, 6'd0, '0, '0));
    send_request(make_req(CMD_USAGE, 4'd0, 7'd0, 6'd0, 64'h8000_0000_0000_0000, '0));
    send_request(make_req(CMD_READ, 4'd0, 7'd0, 6'd0, '0, '0));
    send_request(make_req(CMD_WRITE, 4'd0, 7'd0, 6'd5, '0, 32'hFFFF_0000));
    send_request(make_req(CMD_USAGE, 4'd0, 7'd0, 6'd0, 64'h20, '0));
    drain();

    // Writes now land on a frozen register file
    cfg_write(CfgDecay, 32'd0);
    cfg_write(CfgIncr, 32'hFFFF_FFFF);
    cfg_write(CfgSpareA, 32'd0);
    cfg_write(CfgSpareB, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;

    repeat (RandomItems / 2) send_request(random_request());
    drain();

    cfg_write(CfgDecay, 32'(AlphaOne));
    cfg_write(CfgDecay, 32'd65537);
    cfg_write(CfgIncr, 32'd0);
    cfg_we_i <= 1'b0;

    repeat (RandomItems - RandomItems / 2) send_request(random_request());
    drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("Run: %0d requests, %0d replies, alpha %0d, beta %0h after registration",
             sb.n_requests, sb.n_replies, sb.alpha, sb.beta);
    $display("Outcomes: ok %0d, unknown %0d, range %0d, dup %0d, saturated %0d, zero %0d",
             sb.status_seen[STATUS_OK], sb.status_seen[STATUS_UNKNOWN],
             sb.status_seen[STATUS_RANGE], sb.status_seen[STATUS_DUP],
             sb.status_seen[STATUS_SAT], sb.status_seen[STATUS_ZERO]);
    if (sb.n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/deuc_pkg.sv
rtl/core/deuc_ram.sv
rtl/core/deuc_decay.sv
rtl/core/decayed_expert_usage_counters_core.sv
tb/sv/decayed_expert_usage_counters_core_tb.sv
